@@ design/merge_sorter_macros.svh @@
// ----------------------------------------------------------------------------
// merge_sorter_macros
// assertion helpers for the merge sorter checker
// ----------------------------------------------------------------------------
`ifndef MERGE_SORTER_MACROS_SVH
`define MERGE_SORTER_MACROS_SVH

// same-cycle implication
`define MS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("merge sorter check failed");

// next-cycle implication
`define MS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("merge sorter check failed");

`endif

@@ design/ms_pkg.sv @@
// ----------------------------------------------------------------------------
// ms_pkg
// shared types of the merge sorter
// ----------------------------------------------------------------------------
package ms_pkg;

  localparam int unsigned KeyW = 64;

  typedef struct packed {
    logic [KeyW-1:0] key_in;
    logic            is_last;
  } ms_req_t;

  typedef struct packed {
    logic [KeyW-1:0] key_out;
    logic            last_out;
    logic            overflowed;
  } ms_res_t;

  typedef struct packed {
    logic            vld;
    logic [KeyW-1:0] key;
  } ms_slot_t;

endpackage

@@ design/ms_cell.sv @@
// ----------------------------------------------------------------------------
// ms_cell
// one sorting cell: keeps the smaller key, hands the larger one to the right
// ----------------------------------------------------------------------------
module ms_cell
  import ms_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     shift_i,
  input  ms_slot_t ins_i,
  input  ms_slot_t nbr_i,
  output ms_slot_t hold_o,
  output ms_slot_t pass_o
);

  ms_slot_t held_q, held_d;
  ms_slot_t pass_q, pass_d;

  always_comb begin
    held_d = held_q;
    pass_d = '0;
    if (shift_i) begin
      held_d = nbr_i;
    end else if (ins_i.vld) begin
      if (!held_q.vld) begin
        held_d = ins_i;
      end else if (ins_i.key < held_q.key) begin
        held_d = ins_i;
        pass_d = held_q;
      end else begin
        pass_d = ins_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else begin
      held_q <= held_d;
      pass_q <= pass_d;
    end
  end

  assign hold_o = held_q;
  assign pass_o = pass_q;

endmodule

@@ design/merge_sorter.sv @@
// ----------------------------------------------------------------------------
// merge_sorter
// sorts a set of up to MAX_KEYS unsigned 64-bit keys in ascending order
// ----------------------------------------------------------------------------
// Keys are taken one per cycle while busy_o is low and ripple through a row
// of MAX_KEYS compare cells, each keeping the smaller key. After the request
// marked is_last, busy_o rises while the last keys travel down the row and
// stays high while the n stored keys shift out of the first cell, one result
// per cycle on res_o with res_strobe_o high.
// The receiver cannot stall: every result is valid for that single cycle.
// Keys beyond MAX_KEYS are dropped and set overflowed on every result of
// the set.
module merge_sorter
  import ms_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  ms_req_t req_i,
  output logic    busy_o,
  output logic    res_strobe_o,
  output ms_res_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_KEYS + 1);
  localparam int unsigned TmrW = $clog2(MAX_KEYS + 2);

  typedef enum logic [2:0] {
    StLoad   = 3'b001,
    StSettle = 3'b010,
    StDrain  = 3'b100
  } ms_state_e;

  ms_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [TmrW-1:0] tmr_q, tmr_d;
  logic            drop_q, drop_d;
  ms_slot_t        inj_q, inj_d;
  logic            strobe_q, strobe_d;
  ms_res_t         res_q, res_d;
  logic            shift;
  logic            accept;

  ms_slot_t chain [MAX_KEYS+1];
  ms_slot_t hold  [MAX_KEYS];

  assign accept = start_i && (state_q == StLoad);
  assign shift  = (state_q == StDrain);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    tmr_d    = tmr_q;
    drop_d   = drop_q;
    inj_d    = '0;
    strobe_d = 1'b0;
    res_d    = res_q;
    unique case (state_q)
      StLoad: begin
        if (accept) begin
          if (cnt_q < CntW'(MAX_KEYS)) begin
            inj_d.vld = 1'b1;
            inj_d.key = req_i.key_in;
            cnt_d     = cnt_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (req_i.is_last) begin
            state_d = StSettle;
            tmr_d   = TmrW'(MAX_KEYS + 1);
          end
        end
      end
      StSettle: begin
        tmr_d = tmr_q - 1'b1;
        if (tmr_q == TmrW'(1)) begin
          state_d = StDrain;
          rem_d   = cnt_q;
        end
      end
      StDrain: begin
        strobe_d       = 1'b1;
        res_d.key_out  = hold[0].key;
        res_d.last_out = (rem_q == CntW'(1));
        res_d.overflowed = drop_q;
        rem_d          = rem_q - 1'b1;
        if (rem_q == CntW'(1)) begin
          state_d = StLoad;
          cnt_d   = '0;
          drop_d  = 1'b0;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      cnt_q    <= '0;
      rem_q    <= '0;
      tmr_q    <= '0;
      drop_q   <= 1'b0;
      inj_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      tmr_q    <= tmr_d;
      drop_q   <= drop_d;
      inj_q    <= inj_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign chain[0] = inj_q;

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    ms_slot_t nbr;
    if (i == MAX_KEYS - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = hold[i+1];
    end
    ms_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .ins_i   (chain[i]),
      .nbr_i   (nbr),
      .hold_o  (hold[i]),
      .pass_o  (chain[i+1])
    );
  end

  assign busy_o       = (state_q != StLoad);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

@@ design/ms_checker.sv @@
// ----------------------------------------------------------------------------
// ms_checker
// port-level checks of the merge sorter
// ----------------------------------------------------------------------------
`include "merge_sorter_macros.svh"

module ms_checker
  import ms_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input ms_req_t req_i,
  input logic    busy_o,
  input logic    res_strobe_o,
  input ms_res_t res_o
);

  `MS_ASSERT_NEXT(a_no_res_after_req, start_i && !busy_o, !res_strobe_o)
  `MS_ASSERT_NEXT(a_busy_after_last, start_i && !busy_o && req_i.is_last, busy_o)
  `MS_ASSERT_NEXT(a_gap_after_final, res_strobe_o && res_o.last_out, !res_strobe_o)
  `MS_ASSERT_NEXT(a_burst_runs, res_strobe_o && !res_o.last_out, res_strobe_o)
  `MS_ASSERT_NEXT(a_flag_steady, res_strobe_o && !res_o.last_out, $stable(res_o.overflowed))

endmodule

bind merge_sorter ms_checker u_ms_checker (.*);
